[rtl/hbclru_pkg.sv]
// Shared types, sizes and codes for the block cache directory.
package hbclru_pkg;

	localparam int NUM_SETS = 13;
	localparam int NUM_WAYS = 5;

	localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_IDX_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int TREE_N    = 1 << $clog2(NUM_WAYS);

	localparam int CMD_W    = 2;
	localparam int DEV_W    = 16;
	localparam int BLK_W    = 32;
	localparam int WAY_W    = 4;
	localparam int TICK_W   = 32;
	localparam int REFS_W   = 8;
	localparam int STATUS_W = 2;

	localparam int IN_BITS    = DEV_W + BLK_W + WAY_W + TICK_W;
	localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS   = STATUS_W + 1 + WAY_W + 1;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [REFS_W-1:0] REFS_MAX = '1;

	// block number mod NUM_SETS: fold bytes by 256^i mod NUM_SETS, then reciprocal
	localparam int FOLD_W     = 16;
	localparam int BYTE_MOD0  = 1 % NUM_SETS;
	localparam int BYTE_MOD1  = 256 % NUM_SETS;
	localparam int BYTE_MOD2  = 65536 % NUM_SETS;
	localparam int BYTE_MOD3  = 16777216 % NUM_SETS;
	localparam int DIV_SHIFT  = 22;
	localparam int RECIP      = ((1 << DIV_SHIFT) + NUM_SETS - 1) / NUM_SETS;
	localparam int RECIP_W    = DIV_SHIFT + 1;
	localparam int PROD_W     = FOLD_W + RECIP_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_GET     = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_PIN     = 2'd2,
		CMD_UNPIN   = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_NOBUF = 2'd1,
		STATUS_SAT   = 2'd2
	} status_t;

	typedef struct packed {
		logic [DEV_W-1:0]  device;
		logic [BLK_W-1:0]  block;
		logic [TICK_W-1:0] last_use;
		logic [REFS_W-1:0] refs;
		logic              loaded;
	} entry_t;

	typedef entry_t [NUM_WAYS-1:0] row_t;

endpackage

[rtl/hashed_block_cache_lru_directory.sv]
// Top level of the set-associative block cache directory with stamp-based LRU.
// Each transaction runs in order: the byte fold is registered as it is taken,
// ST_DIV registers the reciprocal-multiply quotient, ST_READ finishes the set
// index and reads the set's row from the single-port row memory, ST_EVAL
// compares all ways and runs the victim search tree, and ST_WRITE writes the row
// back and loads the result register. A new transaction is taken while
// the previous result waits; write-back holds until the result register is free.
// Per-row valid bits make every row read as zero after reset; no clearing pass.
module hashed_block_cache_lru_directory (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// device[15:0], block_number[47:16], way_handle[51:48], now_tick[83:52]
	input  logic [hbclru_pkg::IN_DATA_W-1:0]     s_tdata,
	// cmd[1:0]
	input  logic [hbclru_pkg::CMD_W-1:0]         s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// status[1:0], hit[2], way_taken[6:3], needs_load[7]
	output logic [hbclru_pkg::OUT_DATA_W-1:0]    m_tdata
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_READ  = 5'b00100,
		ST_EVAL  = 5'b01000,
		ST_WRITE = 5'b10000
	} state_t;

	state_t state_q;

	hbclru_pkg::cmd_t                   cmd_q;
	logic [hbclru_pkg::DEV_W-1:0]       dev_q;
	logic [hbclru_pkg::BLK_W-1:0]       blk_q;
	logic [hbclru_pkg::WAY_W-1:0]       handle_q;
	logic [hbclru_pkg::TICK_W-1:0]      tick_q;
	logic [hbclru_pkg::FOLD_W-1:0]      fold_q;
	logic [hbclru_pkg::FOLD_W-1:0]      quot_q;
	logic [hbclru_pkg::SET_W-1:0]       set_q;

	logic [hbclru_pkg::BLK_W-1:0]       in_blk;
	logic [hbclru_pkg::FOLD_W-1:0]      fold;
	logic [hbclru_pkg::PROD_W-1:0]      prod;
	logic [hbclru_pkg::FOLD_W-1:0]      rem_raw;
	logic [hbclru_pkg::FOLD_W-1:0]      rem;
	logic [hbclru_pkg::SET_W-1:0]       set_idx;

	hbclru_pkg::row_t                   mem [hbclru_pkg::NUM_SETS];
	hbclru_pkg::row_t                   rdata_q;
	logic                               rvalid_q;
	logic [hbclru_pkg::NUM_SETS-1:0]    row_valid_q;
	hbclru_pkg::row_t                   row_cur;
	hbclru_pkg::row_t                   new_row;
	logic                               rd_en;
	logic                               wr_en;

	logic [hbclru_pkg::NUM_WAYS-1:0]    hit_vec;
	logic                               hit_any;
	logic [hbclru_pkg::WAY_IDX_W-1:0]   hit_way;
	logic                               in_range;
	logic                               nd_v [2*hbclru_pkg::TREE_N];
	logic [hbclru_pkg::TICK_W-1:0]      nd_s [2*hbclru_pkg::TREE_N];
	logic [hbclru_pkg::WAY_IDX_W-1:0]   nd_w [2*hbclru_pkg::TREE_N];
	logic                               take_l;

	logic                               hit_q;
	logic                               found_q;
	logic                               act_q;
	logic [hbclru_pkg::WAY_IDX_W-1:0]   sel_way_q;

	hbclru_pkg::entry_t                 ent;
	hbclru_pkg::entry_t                 new_ent;
	hbclru_pkg::status_t                res_status;
	logic                               res_hit;
	logic [hbclru_pkg::WAY_W-1:0]       res_way;
	logic                               res_load;

	logic                               out_valid_q;
	logic [hbclru_pkg::OUT_DATA_W-1:0]  out_data_q;
	logic                               out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign out_free = !out_valid_q || m_tready;
	assign rd_en    = (state_q == ST_READ);
	assign wr_en    = (state_q == ST_WRITE) && out_free;

	assign in_blk = s_tdata[hbclru_pkg::DEV_W +: hbclru_pkg::BLK_W];
	assign fold =
		hbclru_pkg::FOLD_W'(in_blk[7:0])   * hbclru_pkg::FOLD_W'(hbclru_pkg::BYTE_MOD0) +
		hbclru_pkg::FOLD_W'(in_blk[15:8])  * hbclru_pkg::FOLD_W'(hbclru_pkg::BYTE_MOD1) +
		hbclru_pkg::FOLD_W'(in_blk[23:16]) * hbclru_pkg::FOLD_W'(hbclru_pkg::BYTE_MOD2) +
		hbclru_pkg::FOLD_W'(in_blk[31:24]) * hbclru_pkg::FOLD_W'(hbclru_pkg::BYTE_MOD3);

	assign prod = hbclru_pkg::PROD_W'(fold_q) * hbclru_pkg::PROD_W'(hbclru_pkg::RECIP);
	assign rem_raw = fold_q - hbclru_pkg::FOLD_W'(quot_q *
		hbclru_pkg::FOLD_W'(hbclru_pkg::NUM_SETS));
	assign rem = (rem_raw >= hbclru_pkg::FOLD_W'(hbclru_pkg::NUM_SETS)) ?
		rem_raw - hbclru_pkg::FOLD_W'(hbclru_pkg::NUM_SETS) : rem_raw;
	assign set_idx = rem[hbclru_pkg::SET_W-1:0];

	assign row_cur  = rvalid_q ? rdata_q : '0;
	assign in_range = {1'b0, handle_q} < (hbclru_pkg::WAY_W + 1)'(hbclru_pkg::NUM_WAYS);

	// tag compare, lowest matching way wins
	always_comb begin
		hit_any = 1'b0;
		hit_way = '0;
		for (int w = hbclru_pkg::NUM_WAYS - 1; w >= 0; w--) begin
			hit_vec[w] = (row_cur[w].device == dev_q) && (row_cur[w].block == blk_q);
			if (hit_vec[w]) begin
				hit_any = 1'b1;
				hit_way = hbclru_pkg::WAY_IDX_W'(w);
			end
		end
	end

	// victim tree: unreferenced way with smallest stamp, ties to the left
	always_comb begin
		take_l = 1'b0;
		for (int i = 0; i < 2 * hbclru_pkg::TREE_N; i++) begin
			nd_v[i] = 1'b0;
			nd_s[i] = '0;
			nd_w[i] = '0;
		end
		for (int w = 0; w < hbclru_pkg::NUM_WAYS; w++) begin
			nd_v[hbclru_pkg::TREE_N + w] = (row_cur[w].refs == '0);
			nd_s[hbclru_pkg::TREE_N + w] = row_cur[w].last_use;
			nd_w[hbclru_pkg::TREE_N + w] = hbclru_pkg::WAY_IDX_W'(w);
		end
		for (int i = hbclru_pkg::TREE_N - 1; i >= 1; i--) begin
			take_l = nd_v[2*i] && (!nd_v[2*i+1] || (nd_s[2*i] <= nd_s[2*i+1]));
			nd_v[i] = nd_v[2*i] || nd_v[2*i+1];
			nd_s[i] = take_l ? nd_s[2*i] : nd_s[2*i+1];
			nd_w[i] = take_l ? nd_w[2*i] : nd_w[2*i+1];
		end
	end

	// modify the selected entry and form the result
	always_comb begin
		ent        = row_cur[sel_way_q];
		new_ent    = ent;
		res_status = hbclru_pkg::STATUS_OK;
		res_hit    = 1'b0;
		res_way    = '0;
		res_load   = 1'b0;
		unique case (cmd_q)
			hbclru_pkg::CMD_GET: begin
				if (hit_q) begin
					if (ent.refs != hbclru_pkg::REFS_MAX) begin
						new_ent.refs = ent.refs + hbclru_pkg::REFS_W'(1);
					end else begin
						res_status = hbclru_pkg::STATUS_SAT;
					end
					new_ent.last_use = tick_q;
					new_ent.loaded   = 1'b1;
					res_hit          = 1'b1;
					res_way          = hbclru_pkg::WAY_W'(sel_way_q);
					res_load         = !ent.loaded;
				end else if (found_q) begin
					new_ent.device   = dev_q;
					new_ent.block    = blk_q;
					new_ent.last_use = tick_q;
					new_ent.refs     = hbclru_pkg::REFS_W'(1);
					new_ent.loaded   = 1'b1;
					res_way          = hbclru_pkg::WAY_W'(sel_way_q);
					res_load         = 1'b1;
				end else begin
					res_status = hbclru_pkg::STATUS_NOBUF;
				end
			end
			hbclru_pkg::CMD_PIN: begin
				if (act_q) begin
					if (ent.refs != hbclru_pkg::REFS_MAX) begin
						new_ent.refs = ent.refs + hbclru_pkg::REFS_W'(1);
					end else begin
						res_status = hbclru_pkg::STATUS_SAT;
					end
				end
			end
			hbclru_pkg::CMD_RELEASE, hbclru_pkg::CMD_UNPIN: begin
				if (act_q) begin
					if (ent.refs != '0) begin
						new_ent.refs = ent.refs - hbclru_pkg::REFS_W'(1);
					end else begin
						res_status = hbclru_pkg::STATUS_SAT;
					end
				end
			end
		endcase
		new_row            = row_cur;
		new_row[sel_way_q] = new_ent;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[set_idx];
		end
		if (wr_en) begin
			mem[set_q] <= new_row;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_q    <= hbclru_pkg::cmd_t'(s_tuser);
			dev_q    <= s_tdata[hbclru_pkg::DEV_W-1:0];
			blk_q    <= in_blk;
			handle_q <= s_tdata[hbclru_pkg::DEV_W + hbclru_pkg::BLK_W +: hbclru_pkg::WAY_W];
			tick_q   <= s_tdata[hbclru_pkg::DEV_W + hbclru_pkg::BLK_W + hbclru_pkg::WAY_W +:
				hbclru_pkg::TICK_W];
			fold_q   <= fold;
		end
		if (state_q == ST_DIV) begin
			quot_q <= prod[hbclru_pkg::DIV_SHIFT +: hbclru_pkg::FOLD_W];
		end
		if (rd_en) begin
			set_q <= set_idx;
		end
		if (state_q == ST_EVAL) begin
			hit_q   <= hit_any;
			found_q <= nd_v[1];
			act_q   <= in_range;
			if (cmd_q == hbclru_pkg::CMD_GET) begin
				sel_way_q <= hit_any ? hit_way : nd_w[1];
			end else if (in_range) begin
				sel_way_q <= handle_q[hbclru_pkg::WAY_IDX_W-1:0];
			end else begin
				sel_way_q <= '0;
			end
		end
		if (wr_en) begin
			out_data_q <= hbclru_pkg::OUT_DATA_W'({res_load, res_way, res_hit, res_status});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			row_valid_q <= '0;
			rvalid_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rvalid_q <= row_valid_q[set_idx];
			end
			if (wr_en) begin
				row_valid_q[set_q] <= 1'b1;
			end
			if (wr_en) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV:  state_q <= ST_READ;
				ST_READ: state_q <= ST_EVAL;
				ST_EVAL: state_q <= ST_WRITE;
				ST_WRITE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/hbclru_checker.sv]
// Port-level checker for the block cache directory and its bind.
module hbclru_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 s_tvalid,
	input logic                                 s_tready,
	input logic                                 m_tvalid,
	input logic                                 m_tready,
	input logic [hbclru_pkg::OUT_DATA_W-1:0]    m_tdata
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second transaction taken while one is in flight");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed or dropped");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == hbclru_pkg::STATUS_OK) ||
			(m_tdata[1:0] == hbclru_pkg::STATUS_NOBUF) ||
			(m_tdata[1:0] == hbclru_pkg::STATUS_SAT))
		else $error("status code out of range");

	a_nobuf_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == hbclru_pkg::STATUS_NOBUF) |-> (m_tdata[7:2] == '0))
		else $error("no-buffer result carries hit, way or load");

endmodule

bind hashed_block_cache_lru_directory hbclru_checker u_hbclru_checker (.*);
